[sv/imu_fifo_packet_gated_averager_assert.svh]
// Assertion macros shared by the averager RTL. Simulation builds get the
// checks; builds with SYNTH defined get empty bodies.
`ifndef IMU_FIFO_PACKET_GATED_AVERAGER_ASSERT_SVH
`define IMU_FIFO_PACKET_GATED_AVERAGER_ASSERT_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define IMUAVG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("imuavg: assertion failed");

// The condition must never be seen at a clock edge outside reset.
`define IMUAVG_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("imuavg: forbidden condition seen");

`else

`define IMUAVG_ASSERT(label, clk, rst_n, prop)
`define IMUAVG_NEVER(label, clk, rst_n, cond)

`endif

`endif

[sv/imuavg_pkg.sv]
package imuavg_pkg;

    localparam int BYTE_W              = 8;
    localparam int VAL_W               = 20;
    localparam int PACKETS_PER_AVERAGE = 16;
    localparam int PACKET_BYTES        = 20;

    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam int CNT_W = $clog2(PACKETS_PER_AVERAGE + 1);
    localparam int SUM_W = VAL_W + $clog2(PACKETS_PER_AVERAGE);
    localparam int MAG_W = SUM_W;
    localparam int STEP_W = $clog2(MAG_W);

    localparam int NUM_AXES       = 6;
    localparam int AXIS_W         = $clog2(NUM_AXES);
    localparam int GYRO_AXIS_BASE = 3;

    // Packet bytes 1..12 hold the high and mid bytes of all six axes.
    localparam int UPPER_BYTES    = 12;
    localparam int RAM_AW         = $clog2(UPPER_BYTES);
    localparam int GYRO_BYTE_BASE = 6;
    localparam int NIB_FIRST      = 'h11;
    localparam int NIB_LAST       = 'h13;

    localparam int HDR_MSG   = 7;
    localparam int HDR_ACCEL = 6;
    localparam int HDR_GYRO  = 5;
    localparam int HDR_WIDE  = 4;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_HIGH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_LOW   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_HIGH  = 8'd3;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_HI,
        S_RD_MID,
        S_JUDGE,
        S_DIV_START,
        S_DIV_WAIT
    } t_state;

endpackage

[sv/imuavg_ifs.sv]
interface imuavg_in_if;
    import imuavg_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packet_byte;

    modport source (output valid, output packet_byte, input ready);
    modport sink (input valid, input packet_byte, output ready);
endinterface

interface imuavg_out_if;
    import imuavg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] accel_x_avg;
    logic signed [VAL_W-1:0] accel_y_avg;
    logic signed [VAL_W-1:0] accel_z_avg;
    logic signed [VAL_W-1:0] gyro_x_avg;
    logic signed [VAL_W-1:0] gyro_y_avg;
    logic signed [VAL_W-1:0] gyro_z_avg;

    modport source (
        output valid, output accel_x_avg, output accel_y_avg, output accel_z_avg,
        output gyro_x_avg, output gyro_y_avg, output gyro_z_avg, input ready
    );
    modport sink (
        input valid, input accel_x_avg, input accel_y_avg, input accel_z_avg,
        input gyro_x_avg, input gyro_y_avg, input gyro_z_avg, output ready
    );
endinterface

interface imuavg_cfg_if;
    import imuavg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_W-1:0]    index;
    logic signed [VAL_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/imuavg_ram.sv]
module imuavg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 12,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/imuavg_div.sv]
`include "imu_fifo_packet_gated_averager_assert.svh"

module imuavg_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [imuavg_pkg::SUM_W-1:0] i_dividend,
    input  logic [imuavg_pkg::CNT_W-1:0]        i_divisor,
    output logic                                o_done,
    output logic signed [imuavg_pkg::VAL_W-1:0] o_quotient
);
    import imuavg_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [MAG_W-1:0]  r_q, n_q;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_den, n_den;
    logic              r_neg, n_neg;

    logic [MAG_W-1:0] dvd_mag;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   rem_sub;
    logic             fits;
    logic [VAL_W-1:0] q_low;

    // Restoring division on the magnitude, one quotient bit per cycle.
    assign dvd_mag = i_dividend[SUM_W-1] ? MAG_W'(-i_dividend) : MAG_W'(i_dividend);
    assign rem_sh  = {r_rem, r_q[MAG_W-1]};
    assign fits    = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_low   = r_q[VAL_W-1:0];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_q    = dvd_mag;
            n_rem  = '0;
            n_den  = i_divisor;
            n_neg  = i_dividend[SUM_W-1];
        end else if (r_busy) begin
            n_q   = {r_q[MAG_W-2:0], fits};
            n_rem = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(MAG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_neg  <= n_neg;
    end

    assign o_done = r_done;

    // An empty count gives a zero mean.
    assign o_quotient = (r_den == '0) ? '0 : signed'(r_neg ? (~q_low + 1'b1) : q_low);

    `IMUAVG_ASSERT(a_done_follows_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))
    `IMUAVG_NEVER(a_no_restart_busy, i_clk, i_rst_n, i_start && r_busy)

endmodule

[sv/imu_fifo_packet_gated_averager.sv]
// Decodes 20-byte IMU FIFO packets, header first, and averages the six
// axes over a window of PACKETS_PER_AVERAGE packets. A 20-bit axis value
// is only summed if its header group is present, the header marks the
// packet usable (bit 4 or bit 7), and it lies inside the inclusive range
// of its group; an empty axis reports 0. Bytes 0x11..0x13 each add the
// states S_RD_HI, S_RD_MID and S_JUDGE per present group, since the
// stored high and mid bytes are read one at a time from a buffer with
// one read port. The last byte of a window starts six divisions, one
// axis after another, on one shared bit-serial divider, and the block
// accepts no byte until the sixth has finished. A new window result
// waits until the previous one has been taken.
`include "imu_fifo_packet_gated_averager_assert.svh"

module imu_fifo_packet_gated_averager (
    input  logic         i_clk,
    input  logic         i_rst_n,
    imuavg_in_if.sink    i_in,
    imuavg_out_if.source o_out,
    imuavg_cfg_if.sink   i_cfg
);
    import imuavg_pkg::*;

    t_state r_state, n_state;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_pkts, n_pkts;
    logic [BYTE_W-1:0] r_hdr, n_hdr;
    logic [BYTE_W-1:0] r_nib, n_nib;
    logic [BYTE_W-1:0] r_hi_byte, n_hi_byte;
    logic [1:0]        r_k, n_k;
    logic              r_grp, n_grp;
    logic              r_do_gyro, n_do_gyro;
    logic              r_win, n_win;
    logic              r_out_valid, n_out_valid;
    logic [AXIS_W-1:0] r_axis, n_axis;

    logic signed [SUM_W-1:0] r_sum [NUM_AXES];
    logic signed [SUM_W-1:0] n_sum [NUM_AXES];
    logic [CNT_W-1:0]        r_cnt [NUM_AXES];
    logic [CNT_W-1:0]        n_cnt [NUM_AXES];
    logic signed [VAL_W-1:0] r_res [NUM_AXES];
    logic signed [VAL_W-1:0] n_res [NUM_AXES];

    logic signed [VAL_W-1:0] r_acc_lo, n_acc_lo;
    logic signed [VAL_W-1:0] r_acc_hi, n_acc_hi;
    logic signed [VAL_W-1:0] r_gyr_lo, n_gyr_lo;
    logic signed [VAL_W-1:0] r_gyr_hi, n_gyr_hi;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [RAM_AW-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic [RAM_AW-1:0] rd_base;

    logic in_acc, out_acc, cfg_acc;
    logic is_store, is_nib, is_last, window_end, hdr_used;
    logic [CNT_W-1:0] pkts_inc;

    logic [3:0]              judge_nib;
    logic signed [VAL_W-1:0] judge_val;
    logic signed [VAL_W-1:0] judge_lo;
    logic signed [VAL_W-1:0] judge_hi;
    logic                    judge_ok;
    logic [AXIS_W-1:0]       judge_axis;

    logic                    div_start;
    logic                    div_done;
    logic signed [VAL_W-1:0] div_quo;

    assign in_acc  = i_in.valid & i_in.ready;
    assign out_acc = o_out.valid & o_out.ready;
    assign cfg_acc = i_cfg.valid & i_cfg.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign is_store   = (r_pos >= POS_W'(1)) && (r_pos <= POS_W'(UPPER_BYTES));
    assign is_nib     = (r_pos >= POS_W'(NIB_FIRST)) && (r_pos <= POS_W'(NIB_LAST));
    assign is_last    = (r_pos == POS_W'(PACKET_BYTES - 1));
    assign pkts_inc   = r_pkts + 1'b1;
    assign window_end = is_last && (pkts_inc >= CNT_W'(PACKETS_PER_AVERAGE));
    assign hdr_used   = r_hdr[HDR_WIDE] | r_hdr[HDR_MSG];

    // Accel bytes sit at 2k and 2k+1 of the buffer, gyro bytes six further on.
    assign rd_base = (r_grp ? RAM_AW'(GYRO_BYTE_BASE) : '0) + RAM_AW'({r_k, 1'b0});

    // Accel takes the upper nibble of the shared byte, gyro the lower one.
    assign judge_nib  = r_grp ? r_nib[3:0] : r_nib[7:4];
    assign judge_val  = signed'({r_hi_byte, ram_rdata, judge_nib});
    assign judge_lo   = r_grp ? r_gyr_lo : r_acc_lo;
    assign judge_hi   = r_grp ? r_gyr_hi : r_acc_hi;
    assign judge_ok   = (judge_val >= judge_lo) && (judge_val <= judge_hi);
    assign judge_axis = r_grp ? (AXIS_W'(GYRO_AXIS_BASE) + AXIS_W'(r_k)) : AXIS_W'(r_k);

    imuavg_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(UPPER_BYTES)
    ) u_upper (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_in.packet_byte),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    imuavg_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_sum[r_axis]),
        .i_divisor (r_cnt[r_axis]),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_pkts      = r_pkts;
        n_hdr       = r_hdr;
        n_nib       = r_nib;
        n_hi_byte   = r_hi_byte;
        n_k         = r_k;
        n_grp       = r_grp;
        n_do_gyro   = r_do_gyro;
        n_win       = r_win;
        n_out_valid = r_out_valid;
        n_axis      = r_axis;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_acc_lo    = r_acc_lo;
        n_acc_hi    = r_acc_hi;
        n_gyr_lo    = r_gyr_lo;
        n_gyr_hi    = r_gyr_hi;
        ram_we      = 1'b0;
        ram_waddr   = RAM_AW'(r_pos - POS_W'(1));
        ram_raddr   = rd_base;
        div_start   = 1'b0;

        if (cfg_acc) begin
            case (i_cfg.index)
                REG_ACCEL_LOW:  n_acc_lo = i_cfg.data;
                REG_ACCEL_HIGH: n_acc_hi = i_cfg.data;
                REG_GYRO_LOW:   n_gyr_lo = i_cfg.data;
                REG_GYRO_HIGH:  n_gyr_hi = i_cfg.data;
                default: ;
            endcase
        end

        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_pos == '0) begin
                        n_hdr = i_in.packet_byte;
                    end
                    ram_we = is_store;
                    if (is_nib) begin
                        n_nib = i_in.packet_byte;
                        n_k   = 2'(r_pos - POS_W'(NIB_FIRST));
                    end
                    if (is_last) begin
                        n_pos = '0;
                        if (window_end) begin
                            n_pkts = '0;
                            n_win  = 1'b1;
                            n_axis = '0;
                        end else begin
                            n_pkts = pkts_inc;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                    if (is_nib && hdr_used && r_hdr[HDR_ACCEL]) begin
                        n_grp     = 1'b0;
                        n_do_gyro = r_hdr[HDR_GYRO];
                        n_state   = S_RD_HI;
                    end else if (is_nib && hdr_used && r_hdr[HDR_GYRO]) begin
                        n_grp     = 1'b1;
                        n_do_gyro = 1'b0;
                        n_state   = S_RD_HI;
                    end else if (window_end) begin
                        n_state = S_DIV_START;
                    end
                end
            end
            S_RD_HI: begin
                n_state = S_RD_MID;
            end
            S_RD_MID: begin
                ram_raddr = rd_base + 1'b1;
                n_hi_byte = ram_rdata;
                n_state   = S_JUDGE;
            end
            S_JUDGE: begin
                if (judge_ok) begin
                    n_sum[judge_axis] = r_sum[judge_axis]
                                      + {{(SUM_W-VAL_W){judge_val[VAL_W-1]}}, judge_val};
                    n_cnt[judge_axis] = r_cnt[judge_axis] + 1'b1;
                end
                if (!r_grp && r_do_gyro) begin
                    n_grp   = 1'b1;
                    n_state = S_RD_HI;
                end else if (r_win) begin
                    n_state = S_DIV_START;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV_START: begin
                // The result registers double as the output beat, so wait for
                // the previous window to drain.
                if (!r_out_valid) begin
                    div_start = 1'b1;
                    n_state   = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_res[r_axis] = div_quo;
                    n_sum[r_axis] = '0;
                    n_cnt[r_axis] = '0;
                    if (r_axis == AXIS_W'(NUM_AXES - 1)) begin
                        n_out_valid = 1'b1;
                        n_win       = 1'b0;
                        n_axis      = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = S_DIV_START;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_pkts      <= '0;
            r_hdr       <= '0;
            r_grp       <= 1'b0;
            r_do_gyro   <= 1'b0;
            r_win       <= 1'b0;
            r_out_valid <= 1'b0;
            r_axis      <= '0;
            r_acc_lo    <= VAL_MIN;
            r_acc_hi    <= VAL_MAX;
            r_gyr_lo    <= VAL_MIN;
            r_gyr_hi    <= VAL_MAX;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_sum[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_pkts      <= n_pkts;
            r_hdr       <= n_hdr;
            r_grp       <= n_grp;
            r_do_gyro   <= n_do_gyro;
            r_win       <= n_win;
            r_out_valid <= n_out_valid;
            r_axis      <= n_axis;
            r_acc_lo    <= n_acc_lo;
            r_acc_hi    <= n_acc_hi;
            r_gyr_lo    <= n_gyr_lo;
            r_gyr_hi    <= n_gyr_hi;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nib     <= n_nib;
        r_hi_byte <= n_hi_byte;
        r_k       <= n_k;
        r_res     <= n_res;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.accel_x_avg = r_res[0];
    assign o_out.accel_y_avg = r_res[1];
    assign o_out.accel_z_avg = r_res[2];
    assign o_out.gyro_x_avg  = r_res[3];
    assign o_out.gyro_y_avg  = r_res[4];
    assign o_out.gyro_z_avg  = r_res[5];

    `IMUAVG_ASSERT(a_pos_in_packet, i_clk, i_rst_n, r_pos < POS_W'(PACKET_BYTES))
    `IMUAVG_ASSERT(a_pkts_in_window, i_clk, i_rst_n, r_pkts < CNT_W'(PACKETS_PER_AVERAGE))
    `IMUAVG_NEVER(a_no_div_over_result, i_clk, i_rst_n, div_start && r_out_valid)
    `IMUAVG_ASSERT(a_result_after_div, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_DIV_WAIT))

endmodule
